FILE: design/emx_pkg.sv
// Package for the ElGamal modular exponentiation engine: field widths, codes,
// register indexes, reset values, transaction structs and sequencer types.
// No dependencies; imported by elgamal_modexp_engine and the testbench.
`timescale 1ns / 1ps

package emx_pkg;

  // Width of the data fields and register words.
  localparam int DATA_W = 32;

  // Default width of the modulus arithmetic.
  localparam int MOD_WIDTH_DEF = 32;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_KEYGEN  = 2'd0;
  localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
  localparam logic [1:0] FUNC_DECRYPT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GENERATOR = 1'b1;

  // Register values after reset.
  localparam logic [DATA_W-1:0] MODULUS_RESET   = 32'd65537;
  localparam logic [DATA_W-1:0] GENERATOR_RESET = 32'd3;

  // One command transaction.
  typedef struct packed {
    logic [1:0]        func;
    logic [DATA_W-1:0] private_key;
    logic [DATA_W-1:0] message;
    logic [DATA_W-1:0] peer_public;
    logic [DATA_W-1:0] nonce;
    logic [DATA_W-1:0] cipher_a;
    logic [DATA_W-1:0] cipher_b;
  } emx_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] out_a;
    logic [DATA_W-1:0] out_b;
  } emx_result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_EXP,
    S_DONE
  } emx_state_t;

  // What the shared multiplier's product is used for.
  typedef enum logic [1:0] {
    OP_RED,
    OP_ACC,
    OP_SQ,
    OP_FIN
  } emx_mul_op_t;

endpackage

FILE: design/elgamal_modexp_engine.sv
// ElGamal key generation, encryption and decryption over a configurable prime.
// One shared bit-serial modular multiplier driven by a small sequencer.
// Depends on emx_pkg.
`timescale 1ns / 1ps

//  Channel   Ports                               Direction  Handshake
//  command   start, busy, cmd                    in         taken when start & !busy
//  result    done, result                        out        one-cycle strobe, no stall
//  config    cfg_write, cfg_index, cfg_data      in         written when cfg_write is high
//
//  Every modular product is launched from idle or S_EXP, runs 32 steps of the
//  shift-add multiplier (one operand bit per cycle) and is written back in S_WB.
//  A power costs one reduction plus up to two products per exponent bit. A zero
//  modulus or an unused code goes straight to S_DONE; otherwise the exponent bits
//  set how long busy stays high, longest for encrypt with all-ones exponents.
//  Reset clears the sequencer and loads the register reset values; there is no
//  clearing pass. The result cannot be stalled; busy stays high until it is shown.

module elgamal_modexp_engine #(
  parameter int MOD_WIDTH = emx_pkg::MOD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  emx_pkg::emx_cmd_t                      cmd,
  output logic                                   done,
  output emx_pkg::emx_result_t                   result,
  input  logic                                   cfg_write,
  input  logic [emx_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [emx_pkg::DATA_W-1:0]             cfg_data
);

  import emx_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  // Configuration registers.
  logic [DATA_W-1:0] modulus_reg;
  logic [DATA_W-1:0] generator_reg;
  logic [MOD_WIDTH-1:0] p_w;

  // Sequencer.
  emx_state_t  state;
  emx_state_t  state_next;
  emx_mul_op_t op;
  logic        step;
  logic        accept;
  logic        fast_exit;
  logic        pow_fin;

  // Latched command fields.
  logic [1:0]        func_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] msg_q;
  logic [DATA_W-1:0] peer_q;
  logic [DATA_W-1:0] nonce_q;
  logic [DATA_W-1:0] cb_q;

  // Exponentiation state.
  logic [MOD_WIDTH-1:0] base;
  logic                 base_zero;
  logic [MOD_WIDTH-1:0] acc;
  logic [DATA_W-1:0]    e;
  logic [MOD_WIDTH-1:0] pow_val;

  // Shared modular multiplier.
  logic [DATA_W-1:0]    mul_a;
  logic [MOD_WIDTH-1:0] mul_b;
  logic [MOD_WIDTH-1:0] mul_r;
  logic [MOD_WIDTH-1:0] mul_r_next;
  logic [CNT_W-1:0]     mul_cnt;
  logic                 mul_last;
  logic [MOD_WIDTH:0]   p_ext;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH-1:0] addend;

  // Result registers.
  logic [DATA_W-1:0] ra;
  logic [DATA_W-1:0] rb;

  // A base that reduces to zero gives zero, even for a zero exponent. A base that
  // only becomes zero later through squaring leaves the accumulator as it is.
  assign p_w       = modulus_reg[MOD_WIDTH-1:0];
  assign accept    = start && !busy;
  assign fast_exit = (p_w == '0) || !(cmd.func inside {FUNC_KEYGEN, FUNC_ENCRYPT, FUNC_DECRYPT});
  assign pow_fin   = base_zero || (e == '0);
  assign pow_val   = base_zero ? '0 : acc;
  assign mul_last  = (mul_cnt == CNT_W'(DATA_W - 1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg   <= MODULUS_RESET;
      generator_reg <= GENERATOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODULUS:   modulus_reg   <= cfg_data;
        CFG_GENERATOR: generator_reg <= cfg_data;
        default:       ;
      endcase
    end
  end

  // One multiplier step: double the remainder, then add b when the operand bit
  // is set, reducing after each with a single compare and subtract.
  always_comb begin
    p_ext   = {1'b0, p_w};
    dbl     = {mul_r, 1'b0};
    dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
    addend  = mul_a[DATA_W-1] ? mul_b : '0;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + {1'b0, addend};
    sum_red = (sum >= p_ext) ? (sum - p_ext) : sum;
    mul_r_next = sum_red[MOD_WIDTH-1:0];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = fast_exit ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        if (mul_last) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        state_next = (op == OP_FIN) ? S_DONE : S_EXP;
      end
      S_EXP: begin
        if (!pow_fin) begin
          state_next = S_MUL;
        end else begin
          case (func_q)
            FUNC_KEYGEN:  state_next = S_DONE;
            FUNC_ENCRYPT: state_next = S_MUL;
            default:      state_next = step ? S_MUL : S_EXP;
          endcase
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy         = (state != S_IDLE);
    done         = (state == S_DONE);
    result.out_a = ra;
    result.out_b = rb;
  end

  // Datapath: operand capture, multiplier steps and write-back of products.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          func_q  <= cmd.func;
          key_q   <= cmd.private_key;
          msg_q   <= cmd.message;
          peer_q  <= cmd.peer_public;
          nonce_q <= cmd.nonce;
          cb_q    <= cmd.cipher_b;
          ra      <= '0;
          rb      <= '0;
          step    <= 1'b0;
          // The first power starts by reducing its base.
          op      <= OP_RED;
          mul_r   <= '0;
          mul_cnt <= '0;
          mul_b   <= MOD_WIDTH'(1);
          if (cmd.func == FUNC_DECRYPT) begin
            mul_a <= cmd.cipher_a;
            e     <= DATA_W'(p_w) - DATA_W'(2);
          end else if (cmd.func == FUNC_ENCRYPT) begin
            mul_a <= generator_reg;
            e     <= cmd.nonce;
          end else begin
            mul_a <= generator_reg;
            e     <= cmd.private_key;
          end
        end
      end
      S_MUL: begin
        mul_r   <= mul_r_next;
        mul_a   <= mul_a << 1;
        mul_cnt <= mul_cnt + CNT_W'(1);
      end
      S_WB: begin
        case (op)
          OP_RED: begin
            base      <= mul_r;
            base_zero <= (mul_r == '0);
            acc       <= MOD_WIDTH'(1);
          end
          OP_ACC: begin
            acc  <= mul_r;
            e[0] <= 1'b0;
          end
          OP_SQ: begin
            base <= mul_r;
            e    <= e >> 1;
          end
          OP_FIN: begin
            if (func_q == FUNC_ENCRYPT) begin
              rb <= DATA_W'(mul_r);
            end else begin
              ra <= DATA_W'(mul_r);
            end
          end
          default: ;
        endcase
      end
      S_EXP: begin
        mul_r   <= '0;
        mul_cnt <= '0;
        if (!pow_fin) begin
          // Multiply into the accumulator for a set bit, otherwise square.
          if (e[0]) begin
            mul_a <= DATA_W'(acc);
            mul_b <= base;
            op    <= OP_ACC;
          end else begin
            mul_a <= DATA_W'(base);
            mul_b <= base;
            op    <= OP_SQ;
          end
        end else begin
          case (func_q)
            FUNC_KEYGEN: begin
              ra <= DATA_W'(pow_val);
            end
            FUNC_ENCRYPT: begin
              if (!step) begin
                // Ciphertext a is done; start the power of the peer key.
                ra    <= DATA_W'(pow_val);
                step  <= 1'b1;
                mul_a <= peer_q;
                mul_b <= MOD_WIDTH'(1);
                op    <= OP_RED;
                e     <= nonce_q;
              end else begin
                mul_a <= msg_q;
                mul_b <= pow_val;
                op    <= OP_FIN;
              end
            end
            default: begin
              if (!step) begin
                // The inverse is already reduced, so it becomes the next base.
                base      <= pow_val;
                base_zero <= (pow_val == '0);
                acc       <= MOD_WIDTH'(1);
                e         <= key_q;
                step      <= 1'b1;
              end else begin
                mul_a <= cb_q;
                mul_b <= pow_val;
                op    <= OP_FIN;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // The sequencer only leaves idle when a transaction is taken.
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without a command transaction");

  // A result follows either a taken command or a run of the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE) || $past(start))
    else $error("result strobe without a command transaction");

  // Every write-back follows a full multiplier run.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> ($past(state) == S_MUL) && $past(mul_last))
    else $error("write-back without a finished product");

  // Only encryption produces a second ciphertext half.
  assert property (@(posedge clk) disable iff (rst)
    (done && (func_q != FUNC_ENCRYPT) && ($past(state) != S_IDLE)) |-> (result.out_b == '0))
    else $error("out_b set for an operation other than encrypt");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for elgamal_modexp_engine: directed table, then random
// keygen/encrypt/decrypt chains, checked against fixed expected values or an in-bench predictor.
// Depends on emx_pkg and the elgamal_modexp_engine RTL.
`timescale 1ns / 1ps

module testbench;
  import emx_pkg::*;

  // Kind of a row in the directed table.
  typedef enum logic {
    ROW_CMD,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_INDEX_W-1:0]     index;
    logic [DATA_W-1:0]          data;
    emx_cmd_t                   c;
    bit                         fixed;
    emx_result_t                res;
  } stim_row_t;

  localparam logic [63:0] MOD_MASK = (64'd1 << MOD_WIDTH_DEF) - 64'd1;
  localparam int NUM_RANDOM = 114;
  localparam int PHASE_LEN  = 20;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  emx_cmd_t                cmd;
  logic                    done;
  emx_result_t             result;
  logic                    cfg_write;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [DATA_W-1:0]       cfg_data;

  // Mirror of the configuration registers, as the block should hold them.
  logic [DATA_W-1:0]       model_modulus;
  logic [DATA_W-1:0]       model_generator;

  emx_result_t             expected_results[$];
  emx_result_t             oldest;
  bit                      cur_fixed;
  emx_result_t             cur_fixed_res;
  bit                      gaps_on;
  int                      err_count;

  stim_row_t               directed[$];
  logic [DATA_W-1:0]       primes[] = '{32'd3, 32'd5, 32'd7, 32'd251, 32'd65521, 32'd65537,
                                        32'd2147483647, 32'd4294967279, 32'd4294967291};

  elgamal_modexp_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Right-to-left square-and-multiply; a base that reduces to zero gives zero.
  function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] expo,
                                            logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] e;
    acc = 64'd1;
    b   = base % m;
    e   = expo;
    if (b == 64'd0) return 64'd0;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc % m;
  endfunction

  // Expected result of one command under the mirrored configuration.
  function automatic emx_result_t elgamal_predict(emx_cmd_t c);
    logic [63:0] p;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [63:0] inv;
    logic [63:0] s;
    emx_result_t r;
    p  = {32'd0, model_modulus} & MOD_MASK;
    ra = 64'd0;
    rb = 64'd0;
    if (p != 64'd0) begin
      case (c.func)
        FUNC_KEYGEN: begin
          ra = power_mod({32'd0, model_generator}, {32'd0, c.private_key}, p);
        end
        FUNC_ENCRYPT: begin
          ra = power_mod({32'd0, model_generator}, {32'd0, c.nonce}, p);
          rb = ({32'd0, c.message} * power_mod({32'd0, c.peer_public}, {32'd0, c.nonce}, p)) % p;
        end
        FUNC_DECRYPT: begin
          inv = power_mod({32'd0, c.cipher_a}, p - 64'd2, p);
          s   = power_mod(inv, {32'd0, c.private_key}, p);
          ra  = (s * {32'd0, c.cipher_b}) % p;
        end
        default: begin
        end
      endcase
    end
    r.out_a = ra[31:0];
    r.out_b = rb[31:0];
    return r;
  endfunction

  function automatic emx_cmd_t make_cmd(logic [1:0] f, logic [31:0] k, logic [31:0] m,
                                        logic [31:0] pp, logic [31:0] n, logic [31:0] ca,
                                        logic [31:0] cb);
    emx_cmd_t c;
    c.func        = f;
    c.private_key = k;
    c.message     = m;
    c.peer_public = pp;
    c.nonce       = n;
    c.cipher_a    = ca;
    c.cipher_b    = cb;
    return c;
  endfunction

  function automatic stim_row_t cmd_row(logic [1:0] f, logic [31:0] k, logic [31:0] m,
                                        logic [31:0] pp, logic [31:0] n, logic [31:0] ca,
                                        logic [31:0] cb, bit fx = 1'b0,
                                        logic [31:0] ea = '0, logic [31:0] eb = '0);
    stim_row_t row;
    row.kind      = ROW_CMD;
    row.index     = CFG_MODULUS;
    row.data      = '0;
    row.c         = make_cmd(f, k, m, pp, n, ca, cb);
    row.fixed     = fx;
    row.res.out_a = ea;
    row.res.out_b = eb;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.index = idx;
    row.data  = val;
    row.c     = '0;
    row.fixed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  // Present one command, after a random gap when gaps are on, and hold it until it is taken.
  // start is left high so that a back-to-back command needs no extra edge.
  task automatic issue(emx_cmd_t c, bit fx, emx_result_t fr);
    int gap;
    gap = gaps_on ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    cmd           <= c;
    cur_fixed     = fx;
    cur_fixed_res = fr;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every outstanding result has been seen.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(negedge clk);
  endtask

  // Registers are only written while the engine is idle.
  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Monitor: mirror register writes, predict on acceptance, check each strobe.
  always @(posedge clk) begin
    if (rst) begin
      model_modulus   = MODULUS_RESET;
      model_generator = GENERATOR_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MODULUS:   model_modulus = cfg_data;
          CFG_GENERATOR: model_generator = cfg_data;
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        if (cur_fixed) expected_results.push_back(cur_fixed_res);
        else expected_results.push_back(elgamal_predict(cmd));
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending: out_a %h out_b %h",
                 result.out_a, result.out_b);
          err_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (result.out_a !== oldest.out_a) begin
            $error("out_a mismatch: expected %h, actual %h", oldest.out_a, result.out_a);
            err_count++;
          end
          if (result.out_b !== oldest.out_b) begin
            $error("out_b mismatch: expected %h, actual %h", oldest.out_b, result.out_b);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog for a hung engine.
  initial begin
    #(28_000_000);
    $display("elgamal_modexp_engine verification failed");
    $finish;
  end

  // Stimulus.
  initial begin
    int              sent;
    int              phase_end;
    logic [31:0]     p;
    logic [31:0]     key;
    logic [31:0]     msg;
    logic [31:0]     nonce;
    logic [31:0]     pub;
    emx_cmd_t        c;
    emx_result_t     ct;

    start         = 1'b0;
    cmd           = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_MODULUS;
    cfg_data      = '0;
    cur_fixed     = 1'b0;
    cur_fixed_res = '0;
    gaps_on       = 1'b1;
    err_count     = 0;
    rst           = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed table, starting from the reset configuration.
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd1, 32'd0));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd3, 32'd0));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'h2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd9, 32'd0));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'd5, 32'd7, 32'd1, 32'h0, 32'h0,
                               1'b1, 32'd3, 32'd35));
    // Zero exponent on a nonzero base, then on a base that is zero mod p.
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'd5, 32'd7, 32'd0, 32'h0, 32'h0,
                               1'b1, 32'd1, 32'd5));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'd9, 32'd65537, 32'd0, 32'h0, 32'h0,
                               1'b1, 32'd1, 32'd0));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'h0, 32'h0));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                               32'hFFFFFFFF, 1'b1, 32'd0, 32'd0));
    // Unreduced cipher_b with a zero private key.
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'h0, 32'h0, 32'h0, 32'h0, 32'd5, 32'd70000,
                               1'b1, 32'd4463, 32'd0));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF,
                               32'hFFFFFFFF));
    directed.push_back(cmd_row(2'b11, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0));
    // Zero generator: zero even for a zero exponent.
    directed.push_back(cfg_row(CFG_GENERATOR, 32'd0));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd0, 32'd0));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'd5, 32'd7, 32'd1, 32'h0, 32'h0,
                               1'b1, 32'd0, 32'd35));
    // Zero modulus answers zero throughout.
    directed.push_back(cfg_row(CFG_MODULUS, 32'd0));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd0, 32'd0));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'h0, 32'h0, 1'b1, 32'd0, 32'd0));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF,
                               32'hFFFFFFFF, 1'b1, 32'd0, 32'd0));
    // Moduli of one and two.
    directed.push_back(cfg_row(CFG_MODULUS, 32'd1));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'd5, 32'd7, 32'd3, 32'h0, 32'h0,
                               1'b1, 32'd0, 32'd0));
    directed.push_back(cfg_row(CFG_MODULUS, 32'd2));
    directed.push_back(cfg_row(CFG_GENERATOR, 32'd3));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'd7, 32'h0, 32'h0, 32'h0, 32'd3, 32'd5,
                               1'b1, 32'd1, 32'd0));
    // Composite modulus where the squared base falls to zero after the last set bit.
    directed.push_back(cfg_row(CFG_MODULUS, 32'd9));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd3, 32'd0));
    // Composite all-ones modulus, generator congruent to zero, then not.
    directed.push_back(cfg_row(CFG_MODULUS, 32'hFFFFFFFF));
    directed.push_back(cfg_row(CFG_GENERATOR, 32'hFFFFFFFF));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'd12345, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd0, 32'd0));
    directed.push_back(cfg_row(CFG_GENERATOR, 32'hFFFFFFFE));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'h0, 32'h0));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'd2,
                               32'hFFFFFFFF));
    // Largest 32-bit prime.
    directed.push_back(cfg_row(CFG_MODULUS, 32'hFFFFFFFB));
    directed.push_back(cfg_row(CFG_GENERATOR, 32'd2));
    directed.push_back(cmd_row(FUNC_ENCRYPT, 32'h0, 32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFE,
                               32'h0, 32'h0));
    directed.push_back(cmd_row(FUNC_DECRYPT, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFA,
                               32'hFFFFFFFF));
    directed.push_back(cmd_row(FUNC_KEYGEN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                               1'b1, 32'd1, 32'd0));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_register(directed[i].index, directed[i].data);
      else issue(directed[i].c, directed[i].fixed, directed[i].res);
    end

    // Random phases: a fresh configuration per phase, mostly well-formed
    // keygen / encrypt / decrypt chains, with noise and corrupted ciphertexts.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      case ($urandom_range(7, 0))
        5:       p = $urandom | 32'd1;
        6:       p = 32'hFFFFFFFF;
        7:       p = 32'd3;
        default: p = primes[$urandom_range(primes.size() - 1, 0)];
      endcase
      write_register(CFG_MODULUS, p);
      write_register(CFG_GENERATOR, ($urandom_range(3, 0) == 0) ? $urandom
                                                                : $urandom_range(p - 1, 1));
      gaps_on   = ($urandom_range(2, 0) != 0);
      phase_end = sent + PHASE_LEN;
      while (sent < phase_end) begin
        if ($urandom_range(3, 0) == 0) begin
          c = make_cmd($urandom_range(3, 0), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
          issue(c, 1'b0, '0);
          sent += 1;
        end else begin
          key   = $urandom;
          msg   = $urandom;
          nonce = $urandom_range(p - 1, 1);
          c     = make_cmd(FUNC_KEYGEN, key, $urandom, $urandom, $urandom, $urandom, $urandom);
          pub   = elgamal_predict(c).out_a;
          issue(c, 1'b0, '0);
          c     = make_cmd(FUNC_ENCRYPT, $urandom, msg, pub, nonce, $urandom, $urandom);
          ct    = elgamal_predict(c);
          issue(c, 1'b0, '0);
          // Now and then the ciphertext is damaged on its way back.
          if ($urandom_range(4, 0) == 0) ct.out_b = ct.out_b ^ (32'd1 << $urandom_range(31, 0));
          c     = make_cmd(FUNC_DECRYPT, key, $urandom, $urandom, $urandom, ct.out_a, ct.out_b);
          issue(c, 1'b0, '0);
          sent += 3;
        end
        if ($urandom_range(9, 0) == 0) settle();
      end
    end

    settle();
    // Room for any stray strobe after the last expected one.
    repeat (4500) @(negedge clk);
    if (err_count == 0) begin
      $display("elgamal_modexp_engine verification clean");
    end else begin
      $display("elgamal_modexp_engine verification failed");
    end
    $finish;
  end

endmodule

FILE: elgamal_modexp_engine.f
design/emx_pkg.sv
design/elgamal_modexp_engine.sv
verif/testbench.sv
